// ===== src/iair_pkg.sv =====
// Types and constants shared by the indexed array insert/remove block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package iair_pkg;

    localparam logic [2:0] MODE_APPEND  = 3'd0;
    localparam logic [2:0] MODE_INSERT  = 3'd1;
    localparam logic [2:0] MODE_READ    = 3'd2;
    localparam logic [2:0] MODE_REMOVE  = 3'd3;
    localparam logic [2:0] MODE_REPLACE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [10:0] position;
        logic [31:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [10:0] used_count;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_INSERT,
        OP_READ,
        OP_REMOVE,
        OP_REPLACE,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [10:0] pos;
        logic [31:0] val;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_DONE
    } t_state;

endpackage

// ===== src/iair_front.sv =====
// Front end: accepts request transactions and decodes the mode into a command.
// Depends on iair_pkg; feeds the command queue.
`timescale 1ns / 1ps

module iair_front
    import iair_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in,
    output logic     o_push,
    input  logic     i_q_full,
    output t_cmd     o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = r_valid && i_q_full;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid   = 1'b1;
            n_cmd.pos = i_in.position;
            n_cmd.val = i_in.item_value;
            case (i_in.mode)
                MODE_APPEND:  n_cmd.op = OP_APPEND;
                MODE_INSERT:  n_cmd.op = OP_INSERT;
                MODE_READ:    n_cmd.op = OP_READ;
                MODE_REMOVE:  n_cmd.op = OP_REMOVE;
                MODE_REPLACE: n_cmd.op = OP_REPLACE;
                default:      n_cmd.op = OP_BAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

// ===== src/iair_fifo.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on iair_pkg for the command type.
`timescale 1ns / 1ps

module iair_fifo
    import iair_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== src/iair_back.sv =====
// Back end: holds the element memory and fill count, executes commands and
// shifts entries one per cycle. Depends on iair_pkg.
`timescale 1ns / 1ps

module iair_back
    import iair_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 11) ? CW : 11;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    t_state               r_state;
    t_state               n_state;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        n_cnt;
    t_op                  r_op;
    t_op                  n_op;
    logic [10:0]          r_pos;
    logic [10:0]          n_pos;
    logic [31:0]          r_val;
    logic [31:0]          n_val;
    logic [1:0]           r_status;
    logic [1:0]           n_status;
    logic [AW-1:0]        r_src;
    logic [AW-1:0]        n_src;
    logic [AW-1:0]        r_last;
    logic [AW-1:0]        n_last;
    logic                 r_wpend;
    logic                 n_wpend;
    logic [AW-1:0]        r_wdst;
    logic [AW-1:0]        n_wdst;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    logic [XW-1:0]        pos_x;
    logic [XW-1:0]        cnt_x;
    logic [AW-1:0]        pos_a;
    logic [CW-1:0]        cnt_m1;
    logic                 is_full;
    logic [1:0]           chk_status;
    logic                 ins_direct;
    logic                 rem_direct;
    logic                 out_free;
    logic [63:0]          val_ext;
    logic [WORD_BITS-1:0] wval;
    logic [63:0]          rd_ext;

    assign pos_x      = XW'(r_pos);
    assign cnt_x      = XW'(r_cnt);
    assign pos_a      = pos_x[AW-1:0];
    assign cnt_m1     = r_cnt - CW'(1);
    assign is_full    = (r_cnt == CW'(DEPTH));
    assign ins_direct = (pos_x == cnt_x);
    assign rem_direct = (pos_a == cnt_m1[AW-1:0]);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign val_ext    = {32'b0, r_val};
    assign wval       = val_ext[WORD_BITS-1:0];
    assign rd_ext     = 64'(r_rdata);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        chk_status = ST_OK;
        case (r_op)
            OP_APPEND: begin
                if (is_full) begin
                    chk_status = ST_FULL;
                end
            end
            OP_INSERT: begin
                if (pos_x > cnt_x) begin
                    chk_status = ST_RANGE;
                end else if (is_full) begin
                    chk_status = ST_FULL;
                end
            end
            OP_READ, OP_REMOVE, OP_REPLACE: begin
                if (pos_x >= cnt_x) begin
                    chk_status = ST_RANGE;
                end
            end
            default: chk_status = ST_RANGE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                if (chk_status == ST_OK) begin
                    if (r_op == OP_INSERT) begin
                        n_state = ins_direct ? S_PUT : S_SHIFT;
                    end else if (r_op == OP_REMOVE && !rem_direct) begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (r_src == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = (r_op == OP_INSERT) ? S_PUT : S_DONE;
            S_PUT:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_status    = r_status;
        n_src       = r_src;
        n_last      = r_last;
        n_wpend     = 1'b0;
        n_wdst      = r_wdst;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        mem_we      = r_wpend;
        mem_waddr   = r_wdst;
        mem_wdata   = r_rdata;
        mem_re      = 1'b0;
        mem_raddr   = pos_a;
        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                n_op    = i_q_cmd.op;
                n_pos   = i_q_cmd.pos;
                n_val   = i_q_cmd.val;
            end
            S_CHECK: begin
                n_status = chk_status;
                if (chk_status == ST_OK) begin
                    case (r_op)
                        OP_APPEND: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_cnt[AW-1:0];
                            mem_wdata = wval;
                            n_cnt     = r_cnt + CW'(1);
                        end
                        OP_REPLACE: begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_a;
                            mem_wdata = wval;
                        end
                        OP_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = pos_a;
                        end
                        OP_INSERT: begin
                            n_src  = cnt_m1[AW-1:0];
                            n_last = pos_a;
                        end
                        OP_REMOVE: begin
                            if (rem_direct) begin
                                n_cnt = cnt_m1;
                            end else begin
                                n_src  = pos_a + AW'(1);
                                n_last = cnt_m1[AW-1:0];
                            end
                        end
                        default: n_status = ST_RANGE;
                    endcase
                end
            end
            S_SHIFT: begin
                mem_re    = 1'b1;
                mem_raddr = r_src;
                n_wpend   = 1'b1;
                if (r_op == OP_INSERT) begin
                    n_wdst = r_src + AW'(1);
                    if (r_src != r_last) begin
                        n_src = r_src - AW'(1);
                    end
                end else begin
                    n_wdst = r_src - AW'(1);
                    if (r_src != r_last) begin
                        n_src = r_src + AW'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (r_op == OP_REMOVE) begin
                    n_cnt = cnt_m1;
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = pos_a;
                mem_wdata = wval;
                n_cnt     = r_cnt + CW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.read_value = (r_op == OP_READ && r_status == ST_OK)
                                       ? rd_ext[31:0] : 32'd0;
                    n_out.status     = r_status;
                    n_out.used_count = 11'(r_cnt);
                end
            end
            default: begin
                n_wpend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_src    <= n_src;
        r_last   <= n_last;
        r_wdst   <= n_wdst;
        r_out    <= n_out;
    end

endmodule

// ===== src/indexed_array_insert_remove.sv =====
// Packed word array with append, insert, read, remove and replace by index.
// A request moves through a decoding front end and a two-entry queue into
// the back end, which owns the element memory (one write and one registered
// read port) and the fill count. An insert or remove shifts the later entries
// one per cycle through the single memory write port; an insert or remove
// that moves no entries skips the shift.
// Each request gives one result: status, the word read by a successful read
// (zero otherwise) and the count after the request.
// Depends on iair_pkg, iair_front, iair_fifo and iair_back.
`timescale 1ns / 1ps

module indexed_array_insert_remove
    import iair_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic push;
    logic q_full;
    t_cmd front_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    iair_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_push     (push),
        .i_q_full   (q_full),
        .o_cmd      (front_cmd)
    );

    iair_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    iair_back #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== src/iair_checker.sv =====
// Port-level assertions for the indexed array block and the bind that
// attaches them to its top level. Depends on iair_pkg.
`timescale 1ns / 1ps

module iair_checker
    import iair_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("Stalled result transaction changed or vanished.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Result valid or input stall right after reset.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK |-> o_out.read_value == 32'd0)
        else $error("Failed request returned a nonzero read value.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |-> o_out.used_count == 11'(DEPTH))
        else $error("Full status with a count below capacity.");

endmodule

bind indexed_array_insert_remove iair_checker #(.DEPTH(DEPTH)) u_iair_checker (.*);

// ===== tb/indexed_array_insert_remove_tb.sv =====
// Self-checking testbench for indexed_array_insert_remove: directed and random requests,
// phases of sender idling and receiver stalls, and a long output hold-off.
// Depends on iair_pkg and the indexed_array_insert_remove RTL.
`timescale 1ns / 1ps

module indexed_array_insert_remove_tb;
    import iair_pkg::*;

    localparam int          SLOTS        = 1024;
    localparam logic [2:0]  MODE_SPARE_5 = 3'd5;
    localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7 = 3'd7;

    class array_scoreboard;
        logic [31:0] words [SLOTS];
        int          used;
        int          errors;
        t_out_item   awaited_responses [$];

        function new();
            used   = 0;
            errors = 0;
            foreach (words[k]) words[k] = '0;
        endfunction

        function t_out_item apply_request(t_in_item req);
            t_out_item rsp;
            int        idx;
            rsp.read_value = '0;
            rsp.status     = ST_OK;
            case (req.mode)
                MODE_APPEND: begin
                    if (used >= SLOTS) begin
                        rsp.status = ST_FULL;
                    end else begin
                        words[used] = req.item_value;
                        used++;
                    end
                end
                MODE_INSERT: begin
                    if (req.position > used) begin
                        rsp.status = ST_RANGE;
                    end else if (used >= SLOTS) begin
                        rsp.status = ST_FULL;
                    end else begin
                        for (idx = used; idx > req.position; idx--) words[idx] = words[idx - 1];
                        words[req.position] = req.item_value;
                        used++;
                    end
                end
                MODE_READ: begin
                    if (req.position >= used) rsp.status = ST_RANGE;
                    else rsp.read_value = words[req.position];
                end
                MODE_REMOVE: begin
                    if (req.position >= used) begin
                        rsp.status = ST_RANGE;
                    end else begin
                        for (idx = req.position; idx + 1 < used; idx++) words[idx] = words[idx + 1];
                        used--;
                    end
                end
                MODE_REPLACE: begin
                    if (req.position >= used) rsp.status = ST_RANGE;
                    else words[req.position] = req.item_value;
                end
                default: rsp.status = ST_RANGE;
            endcase
            rsp.used_count = used[10:0];
            return rsp;
        endfunction

        function void note_request(t_in_item req);
            awaited_responses.insert(awaited_responses.size(), apply_request(req));
        endfunction

        function void check_response(t_out_item got);
            t_out_item want;
            if (awaited_responses.size() == 0) begin
                $display("%0t: unexpected response %h", $time, got);
                errors++;
                return;
            end
            want = awaited_responses[0];
            awaited_responses.delete(0);
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value expected %h actual %h",
                         $time, want.read_value, got.read_value);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.used_count !== want.used_count) begin
                $display("%0t: used_count expected %0d actual %0d",
                         $time, want.used_count, got.used_count);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    array_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    indexed_array_insert_remove uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_in_item make_request(logic [2:0] mode, int pos, logic [31:0] val);
        t_in_item req;
        req.mode       = mode;
        req.position   = pos[10:0];
        req.item_value = val;
        return req;
    endfunction

    function automatic t_in_item random_request(int used);
        t_in_item req;
        int       pick;
        int       grow;
        int       shrink;
        req.item_value = $urandom;
        pick = $urandom_range(0, 9);
        if (pick == 0) req.item_value = '0;
        else if (pick == 1) req.item_value = '1;
        if ($urandom_range(0, 99) < 10) begin
            req.mode     = 3'($urandom_range(0, 7));
            req.position = 11'($urandom);
            return req;
        end
        grow   = (used < 8) ? 60 : ((used > 48) ? 20 : 40);
        shrink = (used > 48) ? 40 : 20;
        pick   = $urandom_range(0, 99);
        if (pick < grow) req.mode = pick[0] ? MODE_INSERT : MODE_APPEND;
        else if (pick < grow + shrink) req.mode = MODE_REMOVE;
        else req.mode = pick[0] ? MODE_READ : MODE_REPLACE;
        if (req.mode == MODE_APPEND) req.position = 11'($urandom);
        else if (req.mode == MODE_INSERT) req.position = 11'($urandom_range(0, used));
        else if (used > 0) req.position = 11'($urandom_range(0, used - 1));
        else req.position = '0;
        if (req.mode != MODE_APPEND && $urandom_range(0, 19) == 0)
            req.position = 11'(used + $urandom_range(0, 1));
        return req;
    endfunction

    task automatic send_item(input t_in_item req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_item(random_request(sb.used));
    endtask

    task automatic run_directed();
        send_item(make_request(MODE_READ, 0, 32'h0));
        send_item(make_request(MODE_REMOVE, 0, 32'h0));
        send_item(make_request(MODE_REPLACE, 0, 32'hDEADBEEF));
        send_item(make_request(MODE_INSERT, 1, 32'h11111111));
        send_item(make_request(MODE_APPEND, 0, 32'h00000000));
        send_item(make_request(MODE_APPEND, 0, 32'hFFFFFFFF));
        send_item(make_request(MODE_INSERT, 0, 32'hA5A5A5A5));
        send_item(make_request(MODE_INSERT, 3, 32'h5A5A5A5A));
        send_item(make_request(MODE_INSERT, 5, 32'h22222222));
        send_item(make_request(MODE_INSERT, 2047, 32'h33333333));
        send_item(make_request(MODE_READ, 0, 32'h0));
        send_item(make_request(MODE_READ, 3, 32'h0));
        send_item(make_request(MODE_READ, 4, 32'h0));
        send_item(make_request(MODE_READ, 2047, 32'hFFFFFFFF));
        send_item(make_request(MODE_REPLACE, 1, 32'h12345678));
        send_item(make_request(MODE_READ, 1, 32'h0));
        send_item(make_request(MODE_REMOVE, 0, 32'h0));
        send_item(make_request(MODE_REMOVE, 2, 32'h0));
        send_item(make_request(MODE_REMOVE, 3, 32'h0));
        send_item(make_request(MODE_SPARE_5, 0, 32'hFFFFFFFF));
        send_item(make_request(MODE_SPARE_6, 0, 32'hFFFFFFFF));
        send_item(make_request(MODE_SPARE_7, 2047, 32'hFFFFFFFF));
        send_item(make_request(MODE_APPEND, 2047, 32'h80000000));
        send_item(make_request(MODE_READ, 1024, 32'h0));
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in           <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(120);
        send_idle_pct  = 68;
        recv_stall_pct = 0;
        send_random(120);
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        send_random(120);
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        send_random(120);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (24) send_item(make_request(MODE_APPEND, $urandom, $urandom));
        repeat (24) send_item(make_request(MODE_READ, $urandom_range(0, sb.used - 1), 32'h0));

        send_idle_pct  = 16;
        recv_stall_pct = 16;
        send_random(30);

        i_in_valid <= 1'b0;
        while (sb.awaited_responses.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited_responses.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_response(o_out);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
